[rtl/image_sample_statistics_unit_defines.svh]
// ----------------------------------------------------------------------------
// Image sample statistics: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, held off during reset.
// ----------------------------------------------------------------------------
`ifndef IMAGE_SAMPLE_STATISTICS_UNIT_DEFINES_SVH
`define IMAGE_SAMPLE_STATISTICS_UNIT_DEFINES_SVH

// Generic property check
`define ISS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A stalled transaction keeps valid and payload
`define ISS_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

[rtl/iss_pkg.sv]
// ----------------------------------------------------------------------------
// Image sample statistics package
// Shared constants, types and the restoring square root step.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int COUNT_BITS   = 20;
  localparam int TALLY_W      = COUNT_BITS + 1;
  localparam int SQRT_STEPS   = 32;
  localparam int SQRT_CNT_W   = $clog2(SQRT_STEPS);
  localparam int DIV_STEPS    = 128;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int FIFO_DEPTH   = 2;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);

  localparam logic [31:0] Q_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_NEG_LIM  = 32'h8000_0000;

  typedef enum logic [2:0] {
    MODE_BYTE       = 3'd0,
    MODE_SHORT      = 3'd1,
    MODE_REAL       = 3'd2,
    MODE_CPLX_SHORT = 3'd3,
    MODE_CPLX_REAL  = 3'd4
  } mode_e;

  // Decoded amplitude handed from front to back
  typedef struct packed {
    logic [31:0] amp;
    logic        last;
    logic        sat;
  } amp_item_t;

  // Partial remainder and root of the bit-pair square root
  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
  } sqrt_acc_t;

  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t a, logic [1:0] pair);
    logic [34:0] shifted;
    logic [34:0] trial;
    sqrt_acc_t   r;
    shifted = {a.rem[32:0], pair};
    trial   = {1'b0, a.root, 2'b01};
    if (shifted >= trial) begin
      r.rem  = shifted - trial;
      r.root = {a.root[30:0], 1'b1};
    end else begin
      r.rem  = shifted;
      r.root = {a.root[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage

[rtl/iss_if.sv]
// ----------------------------------------------------------------------------
// Image sample statistics channels
// Valid/ready channels for samples, results and the mode register.
// ----------------------------------------------------------------------------
interface iss_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] real_word;
  logic [31:0] imag_word;
  logic        last_sample;
  modport source (output valid, real_word, imag_word, last_sample, input ready);
  modport sink   (input valid, real_word, imag_word, last_sample, output ready);
endinterface

interface iss_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] min_value;
  logic signed [31:0] max_value;
  logic signed [31:0] mean_value;
  logic        [31:0] deviation_value;
  logic               overflow_flag;
  modport source (output valid, min_value, max_value, mean_value, deviation_value,
                  overflow_flag, input ready);
  modport sink   (input valid, min_value, max_value, mean_value, deviation_value,
                  overflow_flag, output ready);
endinterface

interface iss_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] sample_mode;
  modport source (output valid, sample_mode, input ready);
  modport sink   (input valid, sample_mode, output ready);
endinterface

[rtl/image_sample_statistics_unit.sv]
// ----------------------------------------------------------------------------
// Image sample statistics unit
// Min, max, mean and standard deviation of an image streamed as samples.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                         transaction
//  in_i     in   real_word, imag_word, last_sample               one sample
//  out_o    out  min/max/mean/deviation_value, overflow_flag     one image result
//  cfg_i    in   sample_mode                                     mode write
//
//  Front: real samples pass decode and hand-off; complex samples pass square,
//  sum and a 32-step bit-pair root. Back: each sample is taken, squared and
//  accumulated; on the last sample add two 128-step long divisions and a 32-step
//  root. A 2-entry queue decouples the two; the result register frees the back
//  end while out_o stalls. Reset clears the statistics; no clearing pass.
// ----------------------------------------------------------------------------
module image_sample_statistics_unit import iss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  iss_in_if.sink    in_i,
  iss_cfg_if.sink   cfg_i,
  iss_out_if.source out_o
);

  amp_item_t front_item, back_item;
  logic      front_valid, front_ready;
  logic      back_valid, back_ready;

  iss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready)
  );

  iss_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (back_item)
  );

  iss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (back_valid),
    .pop_ready_o (back_ready),
    .pop_item_i  (back_item),
    .out_o       (out_o)
  );

endmodule

[rtl/iss_front.sv]
// ----------------------------------------------------------------------------
// Image sample statistics front end
// Holds the mode register, decodes samples, forms complex magnitudes.
// ----------------------------------------------------------------------------
module iss_front import iss_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  iss_in_if.sink         in_i,
  iss_cfg_if.sink        cfg_i,
  output amp_item_t      item_o,
  output logic           item_valid_o,
  input  logic           item_ready_i
);

  typedef enum logic [2:0] {F_IDLE, F_SQUARE, F_SUM, F_ROOT, F_HOLD} fstate_e;

  fstate_e                state_q;
  logic [2:0]             mode_q;
  logic [31:0]            ra_q, ia_q;
  logic                   short_q;
  logic [63:0]            rsq_q, isq_q;
  logic [63:0]            rad_q;
  sqrt_acc_t              acc_q;
  logic [SQRT_CNT_W-1:0]  cnt_q;
  amp_item_t              item_q;

  sqrt_acc_t              acc_next;
  logic [63:0]            sq_sum;

  assign in_i.ready   = (state_q == F_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign item_o       = item_q;
  assign item_valid_o = (state_q == F_HOLD);

  assign acc_next = sqrt_step(acc_q, rad_q[63:62]);
  assign sq_sum   = rsq_q + isq_q;

  // Decode and magnitude sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      mode_q  <= MODE_BYTE;
    end else begin
      if (cfg_i.valid) begin
        mode_q <= cfg_i.sample_mode;
      end
      unique case (state_q)
        F_IDLE: begin
          if (in_i.valid) begin
            item_q.last <= in_i.last_sample;
            item_q.sat  <= 1'b0;
            unique case (mode_q)
              MODE_SHORT: begin
                item_q.amp <= {in_i.real_word[15:0], 16'h0000};
                state_q    <= F_HOLD;
              end
              MODE_REAL: begin
                item_q.amp <= in_i.real_word;
                state_q    <= F_HOLD;
              end
              MODE_CPLX_SHORT: begin
                ra_q    <= {{16{in_i.real_word[15]}}, in_i.real_word[15:0]};
                ia_q    <= {{16{in_i.imag_word[15]}}, in_i.imag_word[15:0]};
                short_q <= 1'b1;
                state_q <= F_SQUARE;
              end
              MODE_CPLX_REAL: begin
                ra_q    <= in_i.real_word;
                ia_q    <= in_i.imag_word;
                short_q <= 1'b0;
                state_q <= F_SQUARE;
              end
              default: begin
                item_q.amp <= {8'h00, in_i.real_word[7:0], 16'h0000};
                state_q    <= F_HOLD;
              end
            endcase
          end
        end
        F_SQUARE: begin
          rsq_q   <= 64'($signed(ra_q) * $signed(ra_q));
          isq_q   <= 64'($signed(ia_q) * $signed(ia_q));
          state_q <= F_SUM;
        end
        F_SUM: begin
          // Short pairs are scaled up by 2^32 before the root
          rad_q   <= short_q ? {sq_sum[31:0], 32'h0} : sq_sum;
          acc_q   <= '0;
          cnt_q   <= '0;
          state_q <= F_ROOT;
        end
        F_ROOT: begin
          acc_q <= acc_next;
          rad_q <= {rad_q[61:0], 2'b00};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
            if (acc_next.root[31]) begin
              item_q.amp <= Q_MAX;
              item_q.sat <= 1'b1;
            end else begin
              item_q.amp <= acc_next.root;
            end
            state_q <= F_HOLD;
          end
        end
        F_HOLD: begin
          if (item_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

[rtl/iss_fifo.sv]
// ----------------------------------------------------------------------------
// Image sample statistics queue
// Short queue of decoded amplitudes between front and back.
// ----------------------------------------------------------------------------
module iss_fifo import iss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  amp_item_t push_item_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output amp_item_t pop_item_o
);

  amp_item_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]     count_q;
  logic                    push, pop;

  assign push_ready_o = (count_q != (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[rtl/iss_back.sv]
// ----------------------------------------------------------------------------
// Image sample statistics back end
// Accumulates min, max, sums and count; computes the image result.
// ----------------------------------------------------------------------------
module iss_back import iss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pop_valid_i,
  output logic      pop_ready_o,
  input  amp_item_t pop_item_i,
  iss_out_if.source out_o
);

  typedef enum logic [3:0] {
    B_IDLE, B_SQUARE, B_ACC, B_PREP, B_DIV1, B_MEAN, B_DIV2, B_SQMEAN, B_VAR,
    B_ROOT, B_OUT
  } bstate_e;

  bstate_e               state_q;
  logic [31:0]           amp_q;
  logic                  last_q, in_sat_q;
  logic [63:0]           sq_q;
  logic [31:0]           min_q, max_q;
  logic [63:0]           sum_q;
  logic [63:0]           sqlo_q, sqhi_q;
  logic [TALLY_W-1:0]    tally_q;
  logic                  sat_q;
  logic                  neg_q;
  logic [127:0]          num_q;
  logic [TALLY_W-1:0]    rem_q;
  logic [DIV_CNT_W-1:0]  dcnt_q;
  logic [31:0]           mean_q;
  logic [63:0]           msq_q, m2_q;
  logic [63:0]           rad_q;
  sqrt_acc_t             acc_q;
  logic [SQRT_CNT_W-1:0] rcnt_q;
  logic                  out_valid_q;
  logic [31:0]           out_min_q, out_max_q, out_mean_q, out_dev_q;
  logic                  out_flag_q;

  // Accumulate datapath
  logic [64:0]  sum65;
  logic         sum_ovf;
  logic [63:0]  sum_next;
  logic [64:0]  lo65;
  logic         sq_sat;
  logic         tally_full;
  logic [TALLY_W:0] rem_sh;
  logic         rem_ge;
  logic [63:0]  sum_mag;
  logic [63:0]  quot;
  sqrt_acc_t    acc_next;

  assign sum65      = {sum_q[63], sum_q} + {{33{amp_q[31]}}, amp_q};
  assign sum_ovf    = sum65[64] != sum65[63];
  assign sum_next   = sum_ovf ? {sum65[64], {63{~sum65[64]}}} : sum65[63:0];
  assign lo65       = {1'b0, sqlo_q} + {1'b0, sq_q};
  assign sq_sat     = lo65[64] && (sqhi_q == '1);
  assign tally_full = (tally_q == '1);
  assign rem_sh     = {rem_q, num_q[127]};
  assign rem_ge     = rem_sh >= {1'b0, tally_q};
  assign sum_mag    = sum_q[63] ? (64'd0 - sum_q) : sum_q;
  assign quot       = num_q[63:0];
  assign acc_next   = sqrt_step(acc_q, rad_q[63:62]);

  assign pop_ready_o           = (state_q == B_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.min_value       = out_min_q;
  assign out_o.max_value       = out_max_q;
  assign out_o.mean_value      = out_mean_q;
  assign out_o.deviation_value = out_dev_q;
  assign out_o.overflow_flag   = out_flag_q;

  // Statistics sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      min_q       <= Q_MAX;
      max_q       <= '0;
      sum_q       <= '0;
      sqlo_q      <= '0;
      sqhi_q      <= '0;
      tally_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_o.valid && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (pop_valid_i) begin
            amp_q    <= pop_item_i.amp;
            last_q   <= pop_item_i.last;
            in_sat_q <= pop_item_i.sat;
            state_q  <= B_SQUARE;
          end
        end
        B_SQUARE: begin
          sq_q    <= 64'($signed(amp_q) * $signed(amp_q));
          state_q <= B_ACC;
        end
        B_ACC: begin
          if ($signed(amp_q) > $signed(max_q)) max_q <= amp_q;
          if ($signed(amp_q) < $signed(min_q)) min_q <= amp_q;
          sum_q <= sum_next;
          // 128-bit square sum, saturating at all ones
          if (lo65[64]) begin
            if (sq_sat) begin
              sqlo_q <= '1;
            end else begin
              sqhi_q <= sqhi_q + 1'b1;
              sqlo_q <= lo65[63:0];
            end
          end else begin
            sqlo_q <= lo65[63:0];
          end
          if (!tally_full) tally_q <= tally_q + 1'b1;
          sat_q   <= sat_q | in_sat_q | sum_ovf | sq_sat | tally_full;
          state_q <= last_q ? B_PREP : B_IDLE;
        end
        B_PREP: begin
          neg_q   <= sum_q[63];
          num_q   <= {64'd0, sum_mag};
          rem_q   <= '0;
          dcnt_q  <= '0;
          state_q <= B_DIV1;
        end
        B_DIV1, B_DIV2: begin
          // One quotient bit per cycle
          rem_q  <= rem_ge ? TALLY_W'(rem_sh - {1'b0, tally_q}) : rem_sh[TALLY_W-1:0];
          num_q  <= {num_q[126:0], rem_ge};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_q <= (state_q == B_DIV1) ? B_MEAN : B_SQMEAN;
          end
        end
        B_MEAN: begin
          if (!neg_q) begin
            mean_q <= (quot > {32'd0, Q_MAX}) ? Q_MAX : quot[31:0];
          end else begin
            mean_q <= (quot > {32'd0, Q_NEG_LIM}) ? Q_NEG_LIM : (32'd0 - quot[31:0]);
          end
          num_q   <= {sqhi_q, sqlo_q};
          rem_q   <= '0;
          dcnt_q  <= '0;
          state_q <= B_DIV2;
        end
        B_SQMEAN: begin
          msq_q   <= (num_q[127:64] != '0) ? '1 : num_q[63:0];
          m2_q    <= 64'($signed(mean_q) * $signed(mean_q));
          state_q <= B_VAR;
        end
        B_VAR: begin
          rad_q   <= (msq_q > m2_q) ? (msq_q - m2_q) : '0;
          acc_q   <= '0;
          rcnt_q  <= '0;
          state_q <= B_ROOT;
        end
        B_ROOT: begin
          acc_q  <= acc_next;
          rad_q  <= {rad_q[61:0], 2'b00};
          rcnt_q <= rcnt_q + 1'b1;
          if (rcnt_q == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
            state_q <= B_OUT;
          end
        end
        B_OUT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_min_q   <= min_q;
            out_max_q   <= max_q;
            out_mean_q  <= mean_q;
            out_dev_q   <= acc_q.root;
            out_flag_q  <= sat_q;
            min_q       <= Q_MAX;
            max_q       <= '0;
            sum_q       <= '0;
            sqlo_q      <= '0;
            sqhi_q      <= '0;
            tally_q     <= '0;
            sat_q       <= 1'b0;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

[rtl/iss_checker.sv]
// ----------------------------------------------------------------------------
// Image sample statistics checker
// Port-level checks on result transactions, bound to the top level.
// ----------------------------------------------------------------------------
`include "image_sample_statistics_unit_defines.svh"

module iss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] min_value_i,
  input logic [31:0] max_value_i,
  input logic [31:0] mean_value_i,
  input logic        overflow_flag_i
);

  // Stalled result holds
  `ISS_ASSERT_HOLD(a_hold_max, out_valid_i, out_ready_i, max_value_i, "result changed under stall")
  // Maximum starts at zero
  `ISS_ASSERT(a_max_nonneg, out_valid_i |-> !max_value_i[31], "negative maximum")
  // Every sample lies between min and max
  `ISS_ASSERT(a_min_le_max, out_valid_i |-> ($signed(min_value_i) <= $signed(max_value_i)), "min above max")
  // Without saturation the mean cannot pass the maximum
  `ISS_ASSERT(a_mean_le_max, (out_valid_i && !overflow_flag_i) |-> ($signed(mean_value_i) <= $signed(max_value_i)), "mean above max")

endmodule

bind image_sample_statistics_unit iss_checker u_iss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .min_value_i     (out_o.min_value),
  .max_value_i     (out_o.max_value),
  .mean_value_i    (out_o.mean_value),
  .overflow_flag_i (out_o.overflow_flag)
);

[tb/image_sample_statistics_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image sample statistics unit testbench
// Streams images in every sample mode through the unit, keeps a running model
// of min, max, sums and count, and checks each image result field by field.
// ----------------------------------------------------------------------------
module image_sample_statistics_unit_tb;
  import iss_pkg::*;

  typedef struct {
    logic signed [31:0] min_v;
    logic signed [31:0] max_v;
    logic signed [31:0] mean_v;
    logic        [31:0] dev_v;
    logic               ovf;
  } image_stats_t;

  logic clk_i;
  logic rst_ni;

  iss_in_if  in_i ();
  iss_cfg_if cfg_i ();
  iss_out_if out_o ();

  image_sample_statistics_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i.sink),
    .cfg_i  (cfg_i.sink),
    .out_o  (out_o.source)
  );

  // Model state
  logic [2:0]          cur_mode;
  logic signed [31:0]  run_min;
  logic signed [31:0]  run_max;
  logic signed [63:0]  amp_sum;
  logic [127:0]        sq_sum;
  logic [TALLY_W-1:0]  tally;
  logic                sat_seen;

  image_stats_t stats_q[$];
  int n_errors;
  int n_samples;
  int n_images;
  int n_sat_images;
  int src_idle_pct;
  int snk_idle_pct;

  // Clock and timeout
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // Floor square root of a 64-bit value
  function automatic logic [31:0] floor_root(logic [63:0] v);
    logic [31:0] r;
    logic [31:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if ({32'd0, t} * {32'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  // Decode one sample into a signed Q16.16 amplitude; magnitude may saturate
  function automatic logic signed [63:0] decode_amp(logic [31:0] re, logic [31:0] im);
    logic signed [63:0] r;
    logic signed [63:0] i;
    logic [63:0]        sq;
    logic [31:0]        mag;
    case (cur_mode)
      MODE_SHORT: return {{32{re[15]}}, re[15:0], 16'h0};
      MODE_REAL:  return {{32{re[31]}}, re};
      MODE_CPLX_SHORT: begin
        r  = {{48{re[15]}}, re[15:0]};
        i  = {{48{im[15]}}, im[15:0]};
        sq = (r * r + i * i) << 32;
      end
      MODE_CPLX_REAL: begin
        r  = {{32{re[31]}}, re};
        i  = {{32{im[31]}}, im};
        sq = r * r + i * i;
      end
      default: return {40'd0, re[7:0], 16'h0};
    endcase
    mag = floor_root(sq);
    if (mag > Q_MAX) begin
      sat_seen = 1'b1;
      mag = Q_MAX;
    end
    return {32'd0, mag};
  endfunction

  task automatic clear_stats();
    run_min  = Q_MAX;
    run_max  = '0;
    amp_sum  = '0;
    sq_sum   = '0;
    tally    = '0;
    sat_seen = 1'b0;
  endtask

  // Fold one accepted sample into the model; queue the result on the last one
  task automatic accumulate_sample(logic [31:0] re, logic [31:0] im, logic last);
    logic signed [63:0] amp;
    logic signed [64:0] s;
    logic [128:0]       q2;
    logic [63:0]        mag;
    logic [63:0]        q;
    logic [127:0]       msq_w;
    logic [63:0]        msq;
    logic [63:0]        m2;
    logic signed [63:0] mean;
    image_stats_t       e;
    amp = decode_amp(re, im);
    if (amp > run_max) run_max = amp[31:0];
    if (amp < run_min) run_min = amp[31:0];
    s = amp_sum + amp;
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      amp_sum = 64'sh7FFF_FFFF_FFFF_FFFF; sat_seen = 1'b1;
    end else if (s < -65'sh0_8000_0000_0000_0000) begin
      amp_sum = 64'sh8000_0000_0000_0000; sat_seen = 1'b1;
    end else begin
      amp_sum = s[63:0];
    end
    q2 = {1'b0, sq_sum} + 129'(64'(amp * amp));
    if (q2[128]) begin
      sq_sum = '1; sat_seen = 1'b1;
    end else begin
      sq_sum = q2[127:0];
    end
    if (tally != '1) tally++;
    else sat_seen = 1'b1;
    if (!last) return;

    mag = amp_sum < 0 ? -amp_sum : amp_sum;
    q = mag / tally;
    if (amp_sum >= 0 && q > Q_MAX) q = Q_MAX;
    if (amp_sum < 0 && q > Q_NEG_LIM) q = Q_NEG_LIM;
    mean  = amp_sum < 0 ? -$signed(q) : $signed(q);
    msq_w = sq_sum / tally;
    msq   = msq_w[127:64] != 0 ? '1 : msq_w[63:0];
    m2    = mean * mean;
    e.min_v  = run_min;
    e.max_v  = run_max;
    e.mean_v = mean[31:0];
    e.dev_v  = floor_root(msq > m2 ? msq - m2 : 64'd0);
    e.ovf    = sat_seen;
    stats_q.push_back(e);
    n_images++;
    if (sat_seen) n_sat_images++;
    clear_stats();
  endtask

  // Result sink: random stalls, compare each transaction with the oldest expectation
  always @(posedge clk_i) begin
    out_o.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    image_stats_t e;
    if (rst_ni && out_o.valid && out_o.ready) begin
      if (stats_q.size() == 0) begin
        $display("%0t ERROR unexpected result min=%h", $time, out_o.min_value);
        n_errors++;
      end else begin
        e = stats_q.pop_front();
        if (out_o.min_value !== e.min_v) begin
          $display("%0t ERROR min exp=%h got=%h", $time, e.min_v, out_o.min_value);
          n_errors++;
        end
        if (out_o.max_value !== e.max_v) begin
          $display("%0t ERROR max exp=%h got=%h", $time, e.max_v, out_o.max_value);
          n_errors++;
        end
        if (out_o.mean_value !== e.mean_v) begin
          $display("%0t ERROR mean exp=%h got=%h", $time, e.mean_v, out_o.mean_value);
          n_errors++;
        end
        if (out_o.deviation_value !== e.dev_v) begin
          $display("%0t ERROR deviation exp=%h got=%h", $time, e.dev_v,
                   out_o.deviation_value);
          n_errors++;
        end
        if (out_o.overflow_flag !== e.ovf) begin
          $display("%0t ERROR overflow exp=%b got=%b", $time, e.ovf, out_o.overflow_flag);
          n_errors++;
        end
      end
    end
  end

  // Send one sample transaction, with a random gap ahead of it
  task automatic send_sample(logic [31:0] re, logic [31:0] im, logic last);
    if ($urandom_range(99) < src_idle_pct) begin
      in_i.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_i.valid       <= 1'b1;
    in_i.real_word   <= re;
    in_i.imag_word   <= im;
    in_i.last_sample <= last;
    do @(posedge clk_i); while (!in_i.ready);
    accumulate_sample(re, im, last);
    n_samples++;
  endtask

  // Wait until every result is back, then let the back end settle
  task automatic drain();
    in_i.valid <= 1'b0;
    while (stats_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_mode(logic [2:0] m);
    drain();
    cfg_i.valid       <= 1'b1;
    cfg_i.sample_mode <= m;
    do @(posedge clk_i); while (!cfg_i.ready);
    cfg_i.valid <= 1'b0;
    cur_mode = m;
  endtask

  // Field values biased toward the edges
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return {16'h0, 1'b1, 15'h0};
      5: return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  // Extremes in every mode, all-negative image, magnitude saturation
  task automatic test_directed();
    write_mode(MODE_BYTE);
    send_sample(32'h0000_0000, 32'h0, 1'b0);
    send_sample(32'hFFFF_FFFF, 32'h0, 1'b1);
    write_mode(MODE_SHORT);
    send_sample(32'h0000_7FFF, 32'h0, 1'b0);
    send_sample(32'hFFFF_8000, 32'h0, 1'b1);
    send_sample(32'h0000_8000, 32'h0, 1'b0);
    send_sample(32'h0000_FFFF, 32'h0, 1'b1);
    write_mode(MODE_REAL);
    send_sample(32'h8000_0000, 32'h0, 1'b1);
    send_sample(32'h7FFF_FFFF, 32'h0, 1'b0);
    send_sample(32'h7FFF_FFFF, 32'h0, 1'b1);
    // pause until the result is in before the next image
    drain();
    send_sample(32'h8000_0000, 32'h0, 1'b0);
    send_sample(32'h7FFF_FFFF, 32'h0, 1'b1);
    write_mode(MODE_CPLX_SHORT);
    send_sample(32'h0000_8000, 32'h0000_8000, 1'b0);
    send_sample(32'h0000_0003, 32'hFFFF_FFFC, 1'b1);
    write_mode(MODE_CPLX_REAL);
    send_sample(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_sample(32'h0003_0000, 32'h0004_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    for (int m = 5; m < 8; m++) begin
      write_mode(m[2:0]);
      send_sample(32'hFFFF_FF80, 32'hFFFF_FFFF, 1'b1);
    end
  endtask

  // Random images in every mode, about n samples
  task automatic test_random_images(int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      write_mode(3'($urandom_range(7)));
      repeat ($urandom_range(2, 5)) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 5);
        for (int k = 0; k < len; k++)
          send_sample(pick_word(), pick_word(), k == len - 1);
        sent += len;
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_i.valid        = 1'b0;
    in_i.real_word    = '0;
    in_i.imag_word    = '0;
    in_i.last_sample  = 1'b0;
    cfg_i.valid       = 1'b0;
    cfg_i.sample_mode = '0;
    out_o.ready       = 1'b0;
    n_errors = 0; n_samples = 0; n_images = 0; n_sat_images = 0;
    src_idle_pct = 21;
    snk_idle_pct = 87;
    cur_mode = MODE_BYTE;
    clear_stats();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_images(140);
    src_idle_pct = 87; snk_idle_pct = 21;
    test_random_images(140);
    src_idle_pct = 0; snk_idle_pct = 0;
    test_random_images(140);
    drain();

    $display("Covered %0d samples in %0d images across all eight mode codes,",
             n_samples, n_images);
    $display("%0d images with saturation; %0d mismatches.", n_sat_images, n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/iss_pkg.sv
rtl/iss_if.sv
rtl/iss_front.sv
rtl/iss_fifo.sv
rtl/iss_back.sv
rtl/image_sample_statistics_unit.sv
rtl/iss_checker.sv
tb/image_sample_statistics_unit_tb.sv
